// ===== design/mfre_pkg.sv =====
// ============================================================================
// mfre_pkg
// Shared types and constants for the monochrome framebuffer raster engine.
// ============================================================================
package mfre_pkg;

    localparam int DEF_COLUMNS = 128;
    localparam int DEF_PAGES   = 8;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_POINT  = 3'd1,
        OP_LINE   = 3'd2,
        OP_CIRCLE = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_POINT,
        ST_LINE,
        ST_CIRC_TEST,
        ST_CIRC_PLOT,
        ST_CIRC_STEP,
        ST_READ,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] radius;
        logic       color;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] done_op;
    } t_res;

endpackage

// ===== design/mfre_if.sv =====
// ============================================================================
// mfre_if
// Valid/ready channel carrying one payload.
// ============================================================================
interface mfre_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mfre_mem.sv =====
// ============================================================================
// mfre_mem
// Byte-wide pixel memory with one write port and one registered read port.
// ============================================================================
module mfre_mem import mfre_pkg::*; #(
    parameter int DEPTH = DEF_COLUMNS * DEF_PAGES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/monochrome_framebuffer_raster_engine_core.sv =====
// ============================================================================
// monochrome_framebuffer_raster_engine_core
// Command sequencer for a page-organized one-bit framebuffer.
// ============================================================================
// Commands arrive on the s_cmd channel and each produces one transfer on the
// m_res channel, carrying the read byte (zero unless a read) and the op code.
// One command is processed at a time; s_cmd.ready is high only while the
// sequencer is idle and no result is waiting.
// Every pixel is a read-modify-write of one memory byte (read, write).
// A clear sweeps one byte per cycle over all PAGES*COLUMNS bytes.
// After reset the sequencer first runs the same clearing sweep and
// accepts no command until it finishes.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds it and takes no new command.
// ============================================================================
module monochrome_framebuffer_raster_engine_core import mfre_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input logic i_clk,
    input logic i_rst_n,
    mfre_if.sink   s_cmd,
    mfre_if.source m_res
);
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = PAGES * 8;

    t_state       r_state, n_state;
    t_state       r_ret, n_ret;
    t_cmd         r_cmd, n_cmd;
    logic [AW:0]  r_cnt, n_cnt;
    logic         r_out_v, n_out_v;
    logic [7:0]   r_out_d, n_out_d;
    logic [7:0]   r_px, n_px, r_py, n_py;
    logic         r_on, n_on;
    logic [AW-1:0] r_addr, n_addr;
    logic [2:0]   r_bit, n_bit;
    logic [8:0]   r_lx, n_lx, r_ly, n_ly, r_ex, n_ex, r_ey, n_ey;
    logic [7:0]   r_dx, n_dx, r_dy, n_dy, r_dist, n_dist;
    logic         r_sxn, n_sxn, r_syn, n_syn, r_sxz, n_sxz, r_syz, n_syz;
    logic [8:0]   r_a, n_a, r_b, n_b;
    logic [2:0]   r_k, n_k;
    logic [17:0]  r_sq, n_sq;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    mfre_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a >= b) ? a - b : b - a;
    endfunction

    logic [7:0] cpx, cpy, ca, cb;
    logic [8:0] exn, eyn;
    logic [17:0] rr, bb2, aabb;

    always_comb begin
        ca = r_a[7:0];
        cb = r_b[7:0];
        case (r_k)
            3'd0: begin cpx = r_cmd.start_x + ca; cpy = r_cmd.start_y - cb; end
            3'd1: begin cpx = r_cmd.start_x - ca; cpy = r_cmd.start_y - cb; end
            3'd2: begin cpx = r_cmd.start_x - ca; cpy = r_cmd.start_y + cb; end
            3'd3: begin cpx = r_cmd.start_x + ca; cpy = r_cmd.start_y + cb; end
            3'd4: begin cpx = r_cmd.start_x + cb; cpy = r_cmd.start_y + ca; end
            3'd5: begin cpx = r_cmd.start_x + cb; cpy = r_cmd.start_y - ca; end
            3'd6: begin cpx = r_cmd.start_x - cb; cpy = r_cmd.start_y - ca; end
            default: begin cpx = r_cmd.start_x - cb; cpy = r_cmd.start_y + ca; end
        endcase
        rr   = 18'(r_cmd.radius) * 18'(r_cmd.radius);
        bb2  = {r_sq[16:0], 1'b0};
        aabb = r_sq;
        exn  = r_ex + 9'(r_dx);
        eyn  = r_ey + 9'(r_dy);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_cmd.valid && !r_out_v) begin
                    case (s_cmd.data.op)
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_POINT:  n_state = ST_POINT;
                        OP_LINE:   n_state = ST_LINE;
                        OP_CIRCLE: n_state = ST_CIRC_TEST;
                        OP_READ:   n_state = ST_READ;
                        default:   n_state = ST_OUT;
                    endcase
                end
            end
            ST_CLEAR:     if (r_cnt == (AW+1)'(DEPTH - 1)) n_state = r_ret;
            ST_POINT:     n_state = ST_PLOT_RD;
            ST_LINE:      n_state = (r_cnt[8:0] > 9'(r_dist)) ? ST_OUT : ST_PLOT_RD;
            ST_CIRC_TEST: n_state = (r_cmd.radius == 8'd0) ? ST_PLOT_RD
                                  : ((bb2 >= rr) ? ST_CIRC_PLOT : ST_OUT);
            ST_CIRC_PLOT: n_state = ST_PLOT_RD;
            ST_CIRC_STEP: n_state = ST_CIRC_TEST;
            ST_READ:      n_state = ST_OUT;
            ST_PLOT_RD:   n_state = ST_PLOT_WR;
            ST_PLOT_WR:   n_state = r_ret;
            ST_OUT:       if (!r_out_v) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ret = r_ret; n_cmd = r_cmd; n_cnt = r_cnt;
        n_out_v = r_out_v; n_out_d = r_out_d;
        n_px = r_px; n_py = r_py; n_on = r_on; n_addr = r_addr; n_bit = r_bit;
        n_lx = r_lx; n_ly = r_ly; n_ex = r_ex; n_ey = r_ey;
        n_dx = r_dx; n_dy = r_dy; n_dist = r_dist;
        n_sxn = r_sxn; n_syn = r_syn; n_sxz = r_sxz; n_syz = r_syz;
        n_a = r_a; n_b = r_b; n_k = r_k; n_sq = r_sq;
        we = 1'b0; waddr = r_addr; wdata = 8'd0; raddr = r_addr;
        s_cmd.ready = 1'b0;
        if (m_res.ready) n_out_v = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_cmd.ready = !r_out_v;
                if (!r_out_v) begin
                    n_cmd = s_cmd.data;
                    n_cnt = '0;
                    n_out_d = 8'd0;
                    n_ret = ST_OUT;
                    n_dx = abs_diff(s_cmd.data.end_x, s_cmd.data.start_x);
                    n_dy = abs_diff(s_cmd.data.end_y, s_cmd.data.start_y);
                    n_sxn = s_cmd.data.end_x < s_cmd.data.start_x;
                    n_syn = s_cmd.data.end_y < s_cmd.data.start_y;
                    n_sxz = s_cmd.data.end_x == s_cmd.data.start_x;
                    n_syz = s_cmd.data.end_y == s_cmd.data.start_y;
                    n_dist = (n_dx > n_dy) ? n_dx : n_dy;
                    n_lx = {1'b0, s_cmd.data.start_x};
                    n_ly = {1'b0, s_cmd.data.start_y};
                    n_ex = '0; n_ey = '0;
                    n_a = '0; n_b = {1'b0, s_cmd.data.radius};
                    n_sq = 18'(s_cmd.data.radius) * 18'(s_cmd.data.radius);
                    n_k = '0;
                    n_on = s_cmd.data.color;
                    n_px = s_cmd.data.start_x; n_py = s_cmd.data.start_y;
                end
            end
            ST_CLEAR: begin
                we = 1'b1; waddr = r_cnt[AW-1:0]; wdata = 8'd0;
                n_cnt = r_cnt + 1'b1;
            end
            ST_POINT: begin
                n_ret = ST_OUT;
            end
            ST_LINE: begin
                n_px = r_lx[7:0]; n_py = r_ly[7:0];
                n_ret = ST_LINE;
                n_cnt = r_cnt + 1'b1;
                n_ex = (exn > 9'(r_dist)) ? exn - 9'(r_dist) : exn;
                n_ey = (eyn > 9'(r_dist)) ? eyn - 9'(r_dist) : eyn;
                if (exn > 9'(r_dist) && !r_sxz) n_lx = r_sxn ? r_lx - 1'b1 : r_lx + 1'b1;
                if (eyn > 9'(r_dist) && !r_syz) n_ly = r_syn ? r_ly - 1'b1 : r_ly + 1'b1;
            end
            ST_CIRC_TEST: begin
                n_on = 1'b1;
                n_ret = ST_OUT;
                n_k = '0;
            end
            ST_CIRC_PLOT: begin
                n_px = cpx; n_py = cpy;
                n_k = r_k + 1'b1;
                n_ret = (r_k == 3'd7) ? ST_CIRC_STEP : ST_CIRC_PLOT;
                if (r_k == 3'd7) n_sq = 18'(r_a + 1'b1) * 18'(r_a + 1'b1) + 18'(r_b) * 18'(r_b);
            end
            ST_CIRC_STEP: begin
                if (aabb > rr) begin
                    n_b = r_b - 1'b1;
                    n_sq = 18'(r_b - 1'b1) * 18'(r_b - 1'b1);
                end else begin
                    n_a = r_a + 1'b1;
                    n_sq = 18'(r_b) * 18'(r_b);
                end
            end
            ST_READ: begin
                if (r_cmd.read_page < 3'(PAGES) || PAGES >= 8) begin
                    raddr = AW'(32'(r_cmd.read_page) * COLUMNS + 32'(r_cmd.read_column));
                end
            end
            ST_PLOT_RD: begin
                raddr = AW'(32'(r_py[7:3]) * COLUMNS + 32'(r_px));
                n_addr = raddr;
                n_bit = r_py[2:0];
            end
            ST_PLOT_WR: begin
                if (32'(r_px) < COLUMNS && 32'(r_py) < ROWS) begin
                    we = 1'b1;
                    wdata = r_on ? (rdata | (8'd1 << r_bit)) : (rdata & ~(8'd1 << r_bit));
                end
            end
            ST_OUT: begin
                if (!r_out_v) n_out_v = 1'b1;
            end
            default: ;
        endcase
        if (r_state == ST_OUT && r_cmd.op == OP_READ && !r_out_v) begin
            n_out_d = (32'(r_cmd.read_page) < PAGES && 32'(r_cmd.read_column) < COLUMNS)
                      ? rdata : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ret   <= ST_IDLE;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_out_v <= n_out_v;
        end
        r_cmd <= n_cmd; r_out_d <= n_out_d;
        r_px <= n_px; r_py <= n_py; r_on <= n_on; r_addr <= n_addr; r_bit <= n_bit;
        r_lx <= n_lx; r_ly <= n_ly; r_ex <= n_ex; r_ey <= n_ey;
        r_dx <= n_dx; r_dy <= n_dy; r_dist <= n_dist;
        r_sxn <= n_sxn; r_syn <= n_syn; r_sxz <= n_sxz; r_syz <= n_syz;
        r_a <= n_a; r_b <= n_b; r_k <= n_k; r_sq <= n_sq;
    end

    assign m_res.valid          = r_out_v;
    assign m_res.data.read_data = r_out_d;
    assign m_res.data.done_op   = r_cmd.op;
endmodule

// ===== test/monochrome_framebuffer_raster_engine_core_test.sv =====
// ============================================================================
// monochrome_framebuffer_raster_engine_core_test
// Self-checking bench for the framebuffer raster engine. A local pixel store
// mirrors the block's memory; each accepted command updates it and predicts
// one result, which is compared field by field with the result transfers.
// ============================================================================
module monochrome_framebuffer_raster_engine_core_test;
    import mfre_pkg::*;

    localparam int NCOL  = DEF_COLUMNS;
    localparam int NPAGE = DEF_PAGES;
    localparam int STALL_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfre_if #(.T(t_cmd)) cmd_ch ();
    mfre_if #(.T(t_res)) res_ch ();

    monochrome_framebuffer_raster_engine_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_cmd  (cmd_ch.sink),
        .m_res  (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] shadow_fb [NPAGE*NCOL];
    t_cmd cmd_queue [$];
    t_res expected_results [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit stimulus_done = 1'b0;
    bit hold_off = 1'b0;

    function automatic void set_pixel(input int x, input int y, input bit on);
        int px;
        int py;
        int idx;
        px = x & 255;
        py = y & 255;
        if (px < NCOL && py < NPAGE * 8) begin
            idx = (py >> 3) * NCOL + px;
            shadow_fb[idx][py & 7] = on;
        end
    endfunction

    function automatic void render_line(input int x0, input int y0, input int x1,
                                        input int y1, input bit on);
        int dx, dy, sx, sy, span, ex, ey, cx, cy;
        dx = x1 - x0;
        dy = y1 - y0;
        sx = 0;
        sy = 0;
        if (dx > 0) sx = 1; else if (dx < 0) begin sx = -1; dx = -dx; end
        if (dy > 0) sy = 1; else if (dy < 0) begin sy = -1; dy = -dy; end
        span = (dx > dy) ? dx : dy;
        ex = 0;
        ey = 0;
        cx = x0;
        cy = y0;
        for (int n = 0; n <= span; n++) begin
            set_pixel(cx, cy, on);
            ex += dx;
            ey += dy;
            if (ex > span) begin ex -= span; cx += sx; end
            if (ey > span) begin ey -= span; cy += sy; end
        end
    endfunction

    function automatic void render_circle(input int cx, input int cy, input int r);
        int a, b, rr;
        a = 0;
        b = r;
        rr = r * r;
        if (r == 0) begin
            set_pixel(cx, cy, 1'b1);
        end else begin
            while (2 * b * b >= rr) begin
                set_pixel(cx + a, cy - b, 1'b1);
                set_pixel(cx - a, cy - b, 1'b1);
                set_pixel(cx - a, cy + b, 1'b1);
                set_pixel(cx + a, cy + b, 1'b1);
                set_pixel(cx + b, cy + a, 1'b1);
                set_pixel(cx + b, cy - a, 1'b1);
                set_pixel(cx - b, cy - a, 1'b1);
                set_pixel(cx - b, cy + a, 1'b1);
                a++;
                if (a * a + b * b - rr > 0) begin
                    b--;
                    a--;
                end
            end
        end
    endfunction

    function automatic t_res execute_command(input t_cmd c);
        t_res r;
        r.read_data = 8'd0;
        r.done_op = c.op;
        case (c.op)
            OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'd0;
            OP_POINT: set_pixel(c.start_x, c.start_y, c.color);
            OP_LINE: render_line(c.start_x, c.start_y, c.end_x, c.end_y, c.color);
            OP_CIRCLE: render_circle(c.start_x, c.start_y, c.radius);
            OP_READ: begin
                if (c.read_page < NPAGE && c.read_column < NCOL)
                    r.read_data = shadow_fb[c.read_page * NCOL + c.read_column];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_cmd make_cmd(input logic [2:0] op, input int x0, input int y0,
                                      input int x1, input int y1, input int rad,
                                      input bit col, input int pg, input int cl);
        t_cmd c;
        c.op = op;
        c.start_x = 8'(x0);
        c.start_y = 8'(y0);
        c.end_x = 8'(x1);
        c.end_y = 8'(y1);
        c.radius = 8'(rad);
        c.color = col;
        c.read_page = 3'(pg);
        c.read_column = 7'(cl);
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int sel;
        c = make_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 127));
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            c.op = OP_READ;
        end else if (sel < 55) begin
            c.op = OP_POINT;
            c.start_x = 8'($urandom_range(0, 140));
            c.start_y = 8'($urandom_range(0, 70));
        end else if (sel < 72) begin
            c.op = OP_LINE;
            if ($urandom_range(0, 3) != 0) begin
                c.start_x = 8'($urandom_range(0, 130));
                c.start_y = 8'($urandom_range(0, 66));
                c.end_x = 8'($urandom_range(0, 130));
                c.end_y = 8'($urandom_range(0, 66));
            end
        end else if (sel < 86) begin
            c.op = OP_CIRCLE;
            if ($urandom_range(0, 3) != 0) c.radius = 8'($urandom_range(0, 40));
        end else if (sel < 88) begin
            c.op = OP_CLEAR;
        end else if (sel >= 95) begin
            c.op = 3'($urandom_range(5, 7));
        end
        return c;
    endfunction

    initial begin
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_POINT, 0, 0, 0, 0, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_POINT, 127, 63, 0, 0, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_POINT, 128, 64, 0, 0, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_POINT, 255, 255, 0, 0, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 7, 127));
        cmd_queue.push_back(make_cmd(OP_LINE, 0, 0, 127, 63, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_LINE, 10, 5, 10, 5, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_LINE, 255, 255, 0, 0, 0, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_LINE, 0, 60, 127, 60, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1));
        cmd_queue.push_back(make_cmd(OP_CIRCLE, 64, 32, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_CIRCLE, 64, 32, 0, 0, 20, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_CIRCLE, 0, 0, 0, 0, 255, 1, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1, 64));
        cmd_queue.push_back(make_cmd(3'd5, 255, 255, 255, 255, 255, 1, 7, 127));
        cmd_queue.push_back(make_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 4, 64));
        cmd_queue.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 1150; i++) cmd_queue.push_back(random_cmd());
    end

    int gap_left = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                expected_results.push_back(execute_command(cmd_ch.data));
            end
            if (cmd_ch.valid && !cmd_ch.ready) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                cmd_ch.valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.data <= cmd_queue.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                cmd_ch.valid <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    int stall_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_off)
                res_ch.ready <= 1'b0;
            else if (stall_phase < 8)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        wait (i_rst_n && cmd_queue.size() < 1100);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data %h op %0d",
                             res_ch.data.read_data, res_ch.data.done_op);
            end else begin
                exp_res = expected_results.pop_front();
                if (res_ch.data.read_data !== exp_res.read_data ||
                    res_ch.data.done_op !== exp_res.done_op) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected data %h op %0d, got data %h op %0d",
                                 exp_res.read_data, exp_res.done_op,
                                 res_ch.data.read_data, res_ch.data.done_op);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
